FILE: hdl/srsw_pkg.sv
// Shared types and constants of the selective-repeat sender window.
package srsw_pkg;

    localparam int SEQ_W        = 7;
    localparam int BASE_W       = 8;
    localparam int WIN_W        = 6;
    localparam int CNT_W        = 8;
    localparam int KIND_W       = 3;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 8;
    localparam int RESULT_LIMIT = 32;

    localparam logic [WIN_W-1:0] WIN_RESET = 6'd4;
    localparam logic [CNT_W-1:0] CNT_RESET = 8'd0;

    localparam logic OP_ACK  = 1'b0;
    localparam logic OP_SEND = 1'b1;

    typedef enum logic [KIND_W-1:0] {
        KIND_ACK  = 3'd0,
        KIND_NEW  = 3'd1,
        KIND_RETX = 3'd2,
        KIND_IDLE = 3'd3,
        KIND_BAD  = 3'd4
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WINDOW = 1'b0,
        REG_COUNT  = 1'b1
    } t_reg_idx;

    // Result request from the sequencer to the output stage.
    typedef struct packed {
        logic              push;
        logic              fin;
        t_kind             kind;
        logic [SEQ_W-1:0]  seq;
        logic [BASE_W-1:0] base;
        logic              done;
    } t_rslt_req;

endpackage

FILE: hdl/srsw_ram.sv
// Generic single-write, single-read RAM with registered read data.
module srsw_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/srsw_rslt.sv
// Result stage: holds one pending result so the final one can carry last_of_run.
module srsw_rslt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  srsw_pkg::t_rslt_req         i_req,
    output logic                        o_strobe,
    output logic [srsw_pkg::KIND_W-1:0] o_kind,
    output logic [srsw_pkg::SEQ_W-1:0]  o_seq_out,
    output logic [srsw_pkg::BASE_W-1:0] o_base_now,
    output logic                        o_all_sent,
    output logic                        o_last_of_run
);

    import srsw_pkg::*;

    logic              r_pend_v,  n_pend_v;
    t_kind             r_pend_kind, n_pend_kind;
    logic [SEQ_W-1:0]  r_pend_seq, n_pend_seq;
    logic              r_stb,  n_stb;
    t_kind             r_kind, n_kind;
    logic [SEQ_W-1:0]  r_seq,  n_seq;
    logic [BASE_W-1:0] r_base, n_base;
    logic              r_done, n_done;
    logic              r_last, n_last;

    always_comb begin
        n_pend_v    = r_pend_v;
        n_pend_kind = r_pend_kind;
        n_pend_seq  = r_pend_seq;
        n_stb       = 1'b0;
        n_kind      = r_kind;
        n_seq       = r_seq;
        n_base      = r_base;
        n_done      = r_done;
        n_last      = r_last;
        if (i_req.fin) begin
            // release the held result as the last one, or report an empty round
            n_stb    = 1'b1;
            n_kind   = r_pend_v ? r_pend_kind : KIND_IDLE;
            n_seq    = r_pend_v ? r_pend_seq : '0;
            n_base   = i_req.base;
            n_done   = i_req.done;
            n_last   = 1'b1;
            n_pend_v = 1'b0;
        end else if (i_req.push) begin
            if (r_pend_v) begin
                n_stb  = 1'b1;
                n_kind = r_pend_kind;
                n_seq  = r_pend_seq;
                n_base = i_req.base;
                n_done = i_req.done;
                n_last = 1'b0;
            end
            n_pend_v    = 1'b1;
            n_pend_kind = i_req.kind;
            n_pend_seq  = i_req.seq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_v <= 1'b0;
            r_stb    <= 1'b0;
        end else begin
            r_pend_v <= n_pend_v;
            r_stb    <= n_stb;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_kind <= n_pend_kind;
        r_pend_seq  <= n_pend_seq;
        r_kind      <= n_kind;
        r_seq       <= n_seq;
        r_base      <= n_base;
        r_done      <= n_done;
        r_last      <= n_last;
    end

    assign o_strobe      = r_stb;
    assign o_kind        = r_kind;
    assign o_seq_out     = r_seq;
    assign o_base_now    = r_base;
    assign o_all_sent    = r_done;
    assign o_last_of_run = r_last;

endmodule

FILE: hdl/srsw_ctrl.sv
// Sequencer: walks the ack bitmap through one read port and steps the window pointers.
module srsw_ctrl #(
    parameter int MAX_PACKETS = 128,
    parameter int MAX_WINDOW  = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic                             i_opcode,
    input  logic [srsw_pkg::SEQ_W-1:0]       i_ack_seq,
    input  logic [srsw_pkg::WIN_W-1:0]       i_win,
    input  logic [srsw_pkg::CNT_W-1:0]       i_cnt,
    output logic                             o_busy,
    output logic                             o_we,
    output logic [$clog2(MAX_PACKETS)-1:0]   o_waddr,
    output logic                             o_wdata,
    output logic [$clog2(MAX_PACKETS)-1:0]   o_raddr,
    input  logic                             i_rdata,
    output srsw_pkg::t_rslt_req              o_req
);

    import srsw_pkg::*;

    localparam int PTR_W     = $clog2(MAX_PACKETS + 1);
    localparam int ADDR_W    = $clog2(MAX_PACKETS);
    localparam int CMP_W     = (PTR_W > CNT_W) ? PTR_W : CNT_W;
    localparam int WIN_LIMIT = (MAX_WINDOW < RESULT_LIMIT) ? MAX_WINDOW : RESULT_LIMIT;
    localparam logic [CMP_W-1:0] CNT_MAX = CMP_W'(MAX_PACKETS);
    localparam logic [WIN_W-1:0] WIN_MAX = WIN_W'(WIN_LIMIT);

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_WALK_RD  = 7'b0000010,
        S_WALK_CHK = 7'b0000100,
        S_PREP     = 7'b0001000,
        S_SCAN     = 7'b0010000,
        S_NEW      = 7'b0100000,
        S_FIN      = 7'b1000000
    } t_state;

    t_state            r_state, n_state;
    logic [PTR_W-1:0]  r_base, n_base;
    logic [PTR_W-1:0]  r_next, n_next;
    logic [PTR_W-1:0]  r_next_end, n_next_end;
    logic [PTR_W-1:0]  r_idx, n_idx;
    logic              r_chk_v, n_chk_v;
    logic [PTR_W-1:0]  r_chk_seq, n_chk_seq;
    logic [SEQ_W-1:0]  r_seq, n_seq;
    logic              r_done, n_done;

    logic [WIN_W-1:0]  eff_win;
    logic [CMP_W-1:0]  eff_cnt;
    logic [CMP_W-1:0]  cnt_ext;
    logic [CMP_W-1:0]  next_ext;
    logic [CMP_W-1:0]  win_ext;
    logic [CMP_W-1:0]  outst_ext;
    logic [CMP_W-1:0]  room;
    logic [CMP_W-1:0]  left_cnt;
    logic [CMP_W-1:0]  n_new;
    logic [CMP_W-1:0]  next_end_ext;
    logic              can_send;
    logic              done_now;
    logic              issue;

    // effective register values and the size of the coming batch of new sends
    always_comb begin
        if (i_win == '0) begin
            eff_win = WIN_W'(1);
        end else if (i_win > WIN_MAX) begin
            eff_win = WIN_MAX;
        end else begin
            eff_win = i_win;
        end
        cnt_ext      = CMP_W'(i_cnt);
        eff_cnt      = (cnt_ext > CNT_MAX) ? CNT_MAX : cnt_ext;
        next_ext     = CMP_W'(r_next);
        win_ext      = CMP_W'(eff_win);
        outst_ext    = CMP_W'(PTR_W'(r_next - r_base));
        room         = win_ext - outst_ext;
        left_cnt     = eff_cnt - next_ext;
        can_send     = (outst_ext < win_ext) && (next_ext < eff_cnt);
        n_new        = can_send ? ((room < left_cnt) ? room : left_cnt) : '0;
        next_end_ext = next_ext + n_new;
        done_now     = (next_ext >= eff_cnt);
    end

    always_comb begin
        n_state    = r_state;
        n_base     = r_base;
        n_next     = r_next;
        n_next_end = r_next_end;
        n_idx      = r_idx;
        n_chk_v    = r_chk_v;
        n_chk_seq  = r_chk_seq;
        n_seq      = r_seq;
        n_done     = r_done;
        o_we       = 1'b0;
        o_waddr    = '0;
        o_wdata    = 1'b0;
        o_raddr    = r_idx[ADDR_W-1:0];
        o_req.push = 1'b0;
        o_req.fin  = 1'b0;
        o_req.kind = KIND_IDLE;
        o_req.seq  = '0;
        o_req.base = BASE_W'(r_base);
        o_req.done = r_done;
        issue      = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_seq = i_ack_seq;
                    if (i_opcode == OP_SEND) begin
                        n_state = S_PREP;
                    end else if (CMP_W'(i_ack_seq) >= next_ext) begin
                        o_req.push = 1'b1;
                        o_req.kind = KIND_BAD;
                        o_req.seq  = i_ack_seq;
                        n_done     = done_now;
                        n_state    = S_FIN;
                    end else begin
                        o_we    = 1'b1;
                        o_waddr = ADDR_W'(i_ack_seq);
                        o_wdata = 1'b1;
                        n_done  = done_now;
                        n_state = S_WALK_RD;
                    end
                end
            end
            S_WALK_RD: begin
                o_raddr = r_base[ADDR_W-1:0];
                if (r_base < r_next) begin
                    n_state = S_WALK_CHK;
                end else begin
                    o_req.push = 1'b1;
                    o_req.kind = KIND_ACK;
                    o_req.seq  = r_seq;
                    n_state    = S_FIN;
                end
            end
            S_WALK_CHK: begin
                if (i_rdata) begin
                    n_base  = r_base + PTR_W'(1);
                    n_state = S_WALK_RD;
                end else begin
                    o_req.push = 1'b1;
                    o_req.kind = KIND_ACK;
                    o_req.seq  = r_seq;
                    n_state    = S_FIN;
                end
            end
            S_PREP: begin
                n_next_end = PTR_W'(next_end_ext);
                n_done     = (next_end_ext >= eff_cnt);
                n_idx      = r_base;
                n_chk_v    = 1'b0;
                n_state    = S_SCAN;
            end
            S_SCAN: begin
                // one read issued per cycle, its bit checked the cycle after
                issue     = (r_idx < r_next);
                n_chk_v   = issue;
                n_chk_seq = r_idx;
                if (issue) begin
                    n_idx = r_idx + PTR_W'(1);
                end
                if (r_chk_v && !i_rdata) begin
                    o_req.push = 1'b1;
                    o_req.kind = KIND_RETX;
                    o_req.seq  = SEQ_W'(r_chk_seq);
                end
                if (!issue && !r_chk_v) begin
                    n_state = (r_next != r_next_end) ? S_NEW : S_FIN;
                end
            end
            S_NEW: begin
                // clear the bit of each freshly sent packet
                o_we       = 1'b1;
                o_waddr    = r_next[ADDR_W-1:0];
                o_wdata    = 1'b0;
                o_req.push = 1'b1;
                o_req.kind = KIND_NEW;
                o_req.seq  = SEQ_W'(r_next);
                n_next     = r_next + PTR_W'(1);
                if (n_next == r_next_end) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                o_req.fin = 1'b1;
                n_state   = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_base  <= '0;
            r_next  <= '0;
            r_chk_v <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_base  <= n_base;
            r_next  <= n_next;
            r_chk_v <= n_chk_v;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_next_end <= n_next_end;
        r_idx      <= n_idx;
        r_chk_seq  <= n_chk_seq;
        r_seq      <= n_seq;
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

FILE: hdl/selective_repeat_sender_window_unit.sv
// Top level of the selective-repeat ARQ sender window.
//
// Usage:
//   Command channel: drive opcode and ack_seq with start; the item transfers at a
//   clock edge where start is high and busy is low. busy stays high until every
//   result of the item has been issued.
//   Result channel: each result shows for one cycle with o_strobe high; the
//   receiver cannot stall, so results go out back to back where the work allows.
//   The last result of an item carries o_last_of_run.
//   Config channel: i_cfg_valid/o_cfg_ready with i_cfg_index and i_cfg_data;
//   ready is always high. Write registers only while busy is low.
// Sequence (the single read port of the ack bitmap RAM orders these steps):
//   bad ack:     busy only in S_FIN; the held result is released from there.
//   good ack:    the bit is written, then each entry the window base moves over
//                is read and checked, plus a check of the unacknowledged entry
//                where the walk stops, then S_FIN. send round: S_PREP, a read and
//                check of each outstanding entry, S_NEW per new send, then S_FIN.
// Reset: synchronous, active low. Window base and next sequence go to zero,
//   window_size to 4, packet_count to 0. The bitmap needs no clearing pass:
//   entries are written when packets are sent; entries above next stay unread.
module selective_repeat_sender_window_unit #(
    parameter int MAX_PACKETS = 128,
    parameter int MAX_WINDOW  = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            i_opcode,
    input  logic [srsw_pkg::SEQ_W-1:0]      i_ack_seq,
    output logic                            o_strobe,
    output logic [srsw_pkg::KIND_W-1:0]     o_kind,
    output logic [srsw_pkg::SEQ_W-1:0]      o_seq_out,
    output logic [srsw_pkg::BASE_W-1:0]     o_base_now,
    output logic                            o_all_sent,
    output logic                            o_last_of_run,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [srsw_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [srsw_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    import srsw_pkg::*;

    localparam int ADDR_W = $clog2(MAX_PACKETS);

    logic [WIN_W-1:0]  r_win;
    logic [CNT_W-1:0]  r_cnt;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic              ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic              ram_rdata;
    t_rslt_req         rslt_req;

    // config registers: always ready, take effect on the next item
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= WIN_RESET;
            r_cnt <= CNT_RESET;
        end else if (i_cfg_valid) begin
            case (t_reg_idx'(i_cfg_index))
                REG_WINDOW: r_win <= i_cfg_data[WIN_W-1:0];
                REG_COUNT:  r_cnt <= i_cfg_data[CNT_W-1:0];
                default: begin
                    r_win <= r_win;
                end
            endcase
        end
    end

    // sequencer: base walk, retransmit scan and new-send issue share one read port
    srsw_ctrl #(
        .MAX_PACKETS (MAX_PACKETS),
        .MAX_WINDOW  (MAX_WINDOW)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_opcode  (i_opcode),
        .i_ack_seq (i_ack_seq),
        .i_win     (r_win),
        .i_cnt     (r_cnt),
        .o_busy    (busy),
        .o_we      (ram_we),
        .o_waddr   (ram_waddr),
        .o_wdata   (ram_wdata),
        .o_raddr   (ram_raddr),
        .i_rdata   (ram_rdata),
        .o_req     (rslt_req)
    );

    // one acknowledged bit per packet
    srsw_ram #(
        .WIDTH (1),
        .DEPTH (MAX_PACKETS)
    ) u_ack_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // hold back one result so the final one can be marked
    srsw_rslt u_rslt (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (rslt_req),
        .o_strobe      (o_strobe),
        .o_kind        (o_kind),
        .o_seq_out     (o_seq_out),
        .o_base_now    (o_base_now),
        .o_all_sent    (o_all_sent),
        .o_last_of_run (o_last_of_run)
    );

    // the run ends with a marked result as busy drops
    a_fin_marks_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $fell(busy) |-> o_strobe && o_last_of_run)
        else $error("busy dropped without a final result");

    // a result seen while idle must be the final one of its run
    a_idle_only_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !busy |-> o_last_of_run)
        else $error("non-final result while idle");

    // back-to-back new sends carry ascending sequence numbers
    a_new_ascend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_kind == KIND_NEW) && $past(o_strobe) && ($past(o_kind) == KIND_NEW)
        |-> o_seq_out == $past(o_seq_out) + 7'd1)
        else $error("new sends out of order");

endmodule
